### hw/rtl/tun_pkg.sv
// tun_pkg: shared constants of the triangle unit normal block.
// No dependencies.
package tun_pkg;
  localparam int CoordWidth = 16;
  localparam int NormWidth  = 16;
  localparam int FracBits   = 14;
  localparam int QWidth     = FracBits + 1;
  localparam int ScaleShift = 2 * FracBits;
  localparam int OneQ14     = 1 << FracBits;
endpackage

### hw/rtl/tun_if.sv
// tun_in_if / tun_out_if: valid/ready channels of the triangle unit normal block.
// Depends on tun_pkg.
interface tun_in_if #(
  parameter int W = tun_pkg::CoordWidth
);
  logic valid;
  logic ready;
  logic signed [W-1:0] a_x, a_y, a_z;
  logic signed [W-1:0] b_x, b_y, b_z;
  logic signed [W-1:0] c_x, c_y, c_z;
  modport source (output valid, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z,
                  input ready);
  modport sink (input valid, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z,
                output ready);
endinterface

interface tun_out_if;
  logic valid;
  logic ready;
  logic signed [tun_pkg::NormWidth-1:0] normal_x, normal_y, normal_z;
  logic degenerate;
  modport source (output valid, normal_x, normal_y, normal_z, degenerate,
                  input ready);
  modport sink (input valid, normal_x, normal_y, normal_z, degenerate,
                output ready);
endinterface

### hw/rtl/tun_cross.sv
// tun_cross: edge vectors and cross product, three register stages.
// Output is sign and magnitude of each component. Depends on nothing else.
module tun_cross #(
  parameter int W = 16
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      en_i,
  input  logic                      valid_i,
  input  logic signed [W-1:0]       a_i [3],
  input  logic signed [W-1:0]       b_i [3],
  input  logic signed [W-1:0]       c_i [3],
  output logic                      valid_o,
  output logic                      neg_o [3],
  output logic [2*(W+1)-1:0]        mag_o [3]
);
  localparam int EW = W + 1;
  localparam int PW = 2 * EW;
  localparam int DW = PW + 1;

  logic [2:0] v_q;
  logic signed [EW-1:0] e1_q [3];
  logic signed [EW-1:0] e2_q [3];
  logic signed [PW-1:0] pa_q [3];
  logic signed [PW-1:0] pb_q [3];
  logic                 neg_q [3];
  logic [PW-1:0]        mag_q [3];
  logic [DW-1:0]        d_w [3];
  logic [DW-1:0]        nd_w [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[1:0], valid_i};
    end
  end

  for (genvar i = 0; i < 3; i++) begin : g_comp
    localparam int J = (i + 1) % 3;
    localparam int K = (i + 2) % 3;

    assign d_w[i]  = {pa_q[i][PW-1], pa_q[i]} - {pb_q[i][PW-1], pb_q[i]};
    assign nd_w[i] = -d_w[i];

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        e1_q[i]  <= {b_i[i][W-1], b_i[i]} - {a_i[i][W-1], a_i[i]};
        e2_q[i]  <= {c_i[i][W-1], c_i[i]} - {a_i[i][W-1], a_i[i]};
        pa_q[i]  <= e1_q[J] * e2_q[K];
        pb_q[i]  <= e1_q[K] * e2_q[J];
        neg_q[i] <= d_w[i][DW-1];
        mag_q[i] <= d_w[i][DW-1] ? nd_w[i][PW-1:0] : d_w[i][PW-1:0];
      end
    end

    assign neg_o[i] = neg_q[i];
    assign mag_o[i] = mag_q[i];
  end

  assign valid_o = v_q[2];
endmodule

### hw/rtl/tun_square.sv
// tun_square: squares of the cross product components from half-width partial
// products, squared length and initial remainders. Depends on tun_pkg.
module tun_square #(
  parameter int W = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              en_i,
  input  logic                              valid_i,
  input  logic                              neg_i [3],
  input  logic [2*(W+1)-1:0]                mag_i [3],
  output logic                              valid_o,
  output logic                              neg_o [3],
  output logic                              deg_o,
  output logic [4*(W+1)+1:0]                len2_o,
  output logic [4*(W+1)+2+tun_pkg::ScaleShift-1:0] r_o [3]
);
  localparam int H  = W + 1;
  localparam int MW = 2 * H;
  localparam int SW = 4 * H;
  localparam int LW = SW + 2;
  localparam int RW = LW + tun_pkg::ScaleShift;

  logic [2:0]    v_q;
  logic [MW-1:0] hh_q [3];
  logic [MW-1:0] hl_q [3];
  logic [MW-1:0] ll_q [3];
  logic [SW-1:0] sq_q [3];
  logic          n1_q [3];
  logic          n2_q [3];
  logic          n3_q [3];
  logic [LW-1:0] len2_q;
  logic [RW-1:0] r_q [3];
  logic          deg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[1:0], valid_i};
    end
  end

  for (genvar i = 0; i < 3; i++) begin : g_comp
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        hh_q[i] <= mag_i[i][MW-1:H] * mag_i[i][MW-1:H];
        hl_q[i] <= mag_i[i][MW-1:H] * mag_i[i][H-1:0];
        ll_q[i] <= mag_i[i][H-1:0] * mag_i[i][H-1:0];
        n1_q[i] <= neg_i[i];
        sq_q[i] <= (SW'(hh_q[i]) << MW) + (SW'(hl_q[i]) << (H + 1)) + SW'(ll_q[i]);
        n2_q[i] <= n1_q[i];
        r_q[i]  <= RW'(sq_q[i]) << tun_pkg::ScaleShift;
        n3_q[i] <= n2_q[i];
      end
    end
    assign neg_o[i] = n3_q[i];
    assign r_o[i]   = r_q[i];
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      len2_q <= LW'(sq_q[0]) + LW'(sq_q[1]) + LW'(sq_q[2]);
      deg_q  <= ~|{sq_q[0], sq_q[1], sq_q[2]};
    end
  end

  assign valid_o = v_q[2];
  assign len2_o  = len2_q;
  assign deg_o   = deg_q;
endmodule

### hw/rtl/tun_digit.sv
// tun_digit: one quotient bit of q = floor(|v| * 2^14 / |V|) for all three
// components, by restoring recurrence on the squares. Depends on tun_pkg.
module tun_digit #(
  parameter int W   = 16,
  parameter int BIT = 0
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  logic                          valid_i,
  input  logic                          deg_i,
  input  logic                          neg_i [3],
  input  logic [4*(W+1)+1:0]            len2_i,
  input  logic [4*(W+1)+2+tun_pkg::ScaleShift-1:0] r_i [3],
  input  logic [4*(W+1)+2+tun_pkg::QWidth-1:0]     t_i [3],
  input  logic [tun_pkg::QWidth-1:0]    q_i [3],
  output logic                          valid_o,
  output logic                          deg_o,
  output logic                          neg_o [3],
  output logic [4*(W+1)+1:0]            len2_o,
  output logic [4*(W+1)+2+tun_pkg::ScaleShift-1:0] r_o [3],
  output logic [4*(W+1)+2+tun_pkg::QWidth-1:0]     t_o [3],
  output logic [tun_pkg::QWidth-1:0]    q_o [3]
);
  localparam int LW = 4 * (W + 1) + 2;
  localparam int RW = LW + tun_pkg::ScaleShift;
  localparam int TW = LW + tun_pkg::QWidth;
  localparam int XW = LW + 2 * tun_pkg::QWidth + 1;
  localparam int QW = tun_pkg::QWidth;

  logic          v_q;
  logic          deg_q;
  logic [LW-1:0] len2_q;
  logic          neg_q [3];
  logic [RW-1:0] r_q [3];
  logic [TW-1:0] t_q [3];
  logic [QW-1:0] q_q [3];
  logic [XW-1:0] tst_w [3];
  logic          take_w [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (en_i) begin
      v_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      deg_q  <= deg_i;
      len2_q <= len2_i;
    end
  end

  for (genvar i = 0; i < 3; i++) begin : g_comp
    // (q + 2^b)^2 * L - q^2 * L = (q*L << b+1) + (L << 2b)
    assign tst_w[i]  = (XW'(t_i[i]) << (BIT + 1)) + (XW'(len2_i) << (2 * BIT));
    assign take_w[i] = tst_w[i] <= XW'(r_i[i]);

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        neg_q[i] <= neg_i[i];
        if (take_w[i]) begin
          r_q[i] <= r_i[i] - tst_w[i][RW-1:0];
          t_q[i] <= t_i[i] + (TW'(len2_i) << BIT);
          q_q[i] <= q_i[i] | (QW'(1) << BIT);
        end else begin
          r_q[i] <= r_i[i];
          t_q[i] <= t_i[i];
          q_q[i] <= q_i[i];
        end
      end
    end

    assign neg_o[i] = neg_q[i];
    assign r_o[i]   = r_q[i];
    assign t_o[i]   = t_q[i];
    assign q_o[i]   = q_q[i];
  end

  assign valid_o = v_q;
  assign deg_o   = deg_q;
  assign len2_o  = len2_q;
endmodule

### hw/rtl/triangle_unit_normal.sv
// triangle_unit_normal: unit surface normal of a triangle, signed Q1.14.
// Depends on tun_pkg, tun_if, tun_cross, tun_square, tun_digit.
//
// Takes one triangle per cycle while the output is not stalled: three
// stages form the edges and the cross product, three square it from half-width
// partial products, fifteen resolve one quotient bit each of the exact
// rounded-toward-zero division by the length, and one registers the result.
// A stall on the output holds every stage in place. A zero cross product
// gives a zero normal with degenerate set.
module triangle_unit_normal #(
  parameter int COORD_WIDTH = tun_pkg::CoordWidth
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  tun_in_if.sink    in_i,
  tun_out_if.source out_o
);
  localparam int W  = COORD_WIDTH;
  localparam int MW = 2 * (W + 1);
  localparam int LW = 4 * (W + 1) + 2;
  localparam int RW = LW + tun_pkg::ScaleShift;
  localparam int TW = LW + tun_pkg::QWidth;
  localparam int QW = tun_pkg::QWidth;
  localparam int NW = tun_pkg::NormWidth;
  localparam int ND = QW;

  logic en;
  logic signed [W-1:0] a_w [3];
  logic signed [W-1:0] b_w [3];
  logic signed [W-1:0] c_w [3];
  logic          cv_w;
  logic          cneg_w [3];
  logic [MW-1:0] cmag_w [3];

  logic          dv_w   [ND+1];
  logic          ddeg_w [ND+1];
  logic          dneg_w [ND+1][3];
  logic [LW-1:0] dlen_w [ND+1];
  logic [RW-1:0] dr_w   [ND+1][3];
  logic [TW-1:0] dt_w   [ND+1][3];
  logic [QW-1:0] dq_w   [ND+1][3];

  logic          out_v_q;
  logic          deg_q;
  logic [NW-1:0] nrm_q [3];
  logic [NW-1:0] nrm_d [3];

  assign en       = !out_v_q || out_o.ready;
  assign in_i.ready = en;

  assign a_w[0] = in_i.a_x;
  assign a_w[1] = in_i.a_y;
  assign a_w[2] = in_i.a_z;
  assign b_w[0] = in_i.b_x;
  assign b_w[1] = in_i.b_y;
  assign b_w[2] = in_i.b_z;
  assign c_w[0] = in_i.c_x;
  assign c_w[1] = in_i.c_y;
  assign c_w[2] = in_i.c_z;

  tun_cross #(.W(W)) u_cross (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_i.valid),
    .a_i     (a_w),
    .b_i     (b_w),
    .c_i     (c_w),
    .valid_o (cv_w),
    .neg_o   (cneg_w),
    .mag_o   (cmag_w)
  );

  tun_square #(.W(W)) u_square (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (cv_w),
    .neg_i   (cneg_w),
    .mag_i   (cmag_w),
    .valid_o (dv_w[0]),
    .neg_o   (dneg_w[0]),
    .deg_o   (ddeg_w[0]),
    .len2_o  (dlen_w[0]),
    .r_o     (dr_w[0])
  );

  for (genvar i = 0; i < 3; i++) begin : g_init
    assign dt_w[0][i] = '0;
    assign dq_w[0][i] = '0;
  end

  for (genvar k = 0; k < ND; k++) begin : g_digit
    tun_digit #(.W(W), .BIT(ND - 1 - k)) u_digit (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (dv_w[k]),
      .deg_i   (ddeg_w[k]),
      .neg_i   (dneg_w[k]),
      .len2_i  (dlen_w[k]),
      .r_i     (dr_w[k]),
      .t_i     (dt_w[k]),
      .q_i     (dq_w[k]),
      .valid_o (dv_w[k+1]),
      .deg_o   (ddeg_w[k+1]),
      .neg_o   (dneg_w[k+1]),
      .len2_o  (dlen_w[k+1]),
      .r_o     (dr_w[k+1]),
      .t_o     (dt_w[k+1]),
      .q_o     (dq_w[k+1])
    );
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (ddeg_w[ND]) begin
        nrm_d[i] = '0;
      end else if (dneg_w[ND][i]) begin
        nrm_d[i] = -NW'(dq_w[ND][i]);
      end else begin
        nrm_d[i] = NW'(dq_w[ND][i]);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (en) begin
      out_v_q <= dv_w[ND];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      nrm_q <= nrm_d;
      deg_q <= ddeg_w[ND];
    end
  end

  assign out_o.valid      = out_v_q;
  assign out_o.normal_x   = nrm_q[0];
  assign out_o.normal_y   = nrm_q[1];
  assign out_o.normal_z   = nrm_q[2];
  assign out_o.degenerate = deg_q;

  a_deg_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.degenerate |->
      out_o.normal_x == '0 && out_o.normal_y == '0 && out_o.normal_z == '0)
    else $error("degenerate item with nonzero normal");

  a_nondeg_nonzero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && !out_o.degenerate |->
      out_o.normal_x != '0 || out_o.normal_y != '0 || out_o.normal_z != '0)
    else $error("nondegenerate item with zero normal");

  a_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |->
      out_o.normal_x <= NW'(tun_pkg::OneQ14) && out_o.normal_x >= -NW'(tun_pkg::OneQ14)
      && out_o.normal_y <= NW'(tun_pkg::OneQ14) && out_o.normal_y >= -NW'(tun_pkg::OneQ14)
      && out_o.normal_z <= NW'(tun_pkg::OneQ14) && out_o.normal_z >= -NW'(tun_pkg::OneQ14))
    else $error("normal component out of unit range");

  a_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(dv_w[ND]) && $stable(cv_w))
    else $error("pipeline moved during stall");
endmodule
